>>> hw/rtl/tukey_radial_window_weight_defines.svh
// ----------------------------------------------------------------------------
// tukey radial window weight assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TUKEY_RADIAL_WINDOW_WEIGHT_DEFINES_SVH
`define TUKEY_RADIAL_WINDOW_WEIGHT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define TWR_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define TWR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/twr_pkg.sv
// ----------------------------------------------------------------------------
// twr_pkg
// widths, register indexes, constants and step functions of the radial
// tukey window weight pipeline
// ----------------------------------------------------------------------------
package twr_pkg;

    localparam int COORD_W  = 12;
    localparam int CFG_W    = 16;
    localparam int WEIGHT_W = 16;
    localparam int IDX_W    = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_TAPER  = 3'd0;
    localparam logic [IDX_W-1:0] REG_FLOOR  = 3'd1;
    localparam logic [IDX_W-1:0] REG_SIZE_X = 3'd2;
    localparam logic [IDX_W-1:0] REG_SIZE_Y = 3'd3;
    localparam logic [IDX_W-1:0] REG_SIZE_Z = 3'd4;

    localparam logic [15:0] ONE_Q15 = 16'd32768;

    // per-axis divider: 19 quotient bits, two per stage
    localparam int AX_Q_BITS     = 19;
    localparam int AX_DIV_STAGES = 10;
    // square root: 17 result bits, two per stage
    localparam int SQRT_BITS     = 17;
    localparam int SQRT_STAGES   = 9;
    // taper phase divider: 16 quotient bits, two per stage
    localparam int PH_Q_BITS     = 16;
    localparam int PH_STAGES     = 8;

    // ceil(2^21 / 3), exact floor(sum/3) for sum below 2^21
    localparam logic [19:0] RECIP3 = 20'd699051;

    // odd polynomial for sin(pi*u), Q28
    localparam logic [30:0] SIN_C1 = 31'd843314857;
    localparam logic [30:0] SIN_C3 = 31'd1387197333;
    localparam logic [30:0] SIN_C5 = 31'd684554447;
    localparam logic [30:0] SIN_C7 = 31'd160863847;
    localparam logic [30:0] SIN_C9 = 31'd22050870;

    typedef struct packed {
        logic [37:0] rem;
        logic [18:0] quo;
    } axdiv_t;

    typedef struct packed {
        logic [32:0] rem;
        logic [16:0] res;
    } sqrt_t;

    typedef struct packed {
        logic [30:0] rem;
        logic [15:0] quo;
    } phdiv_t;

    // one restoring step of the per-axis divider at quotient bit k
    function automatic axdiv_t axdiv_step(axdiv_t st, logic [23:0] den, int k);
        axdiv_t      nx;
        logic [42:0] sh;
        nx = st;
        sh = {19'd0, den} << k;
        if ({5'd0, st.rem} >= sh)
        begin
            nx.rem = st.rem - sh[37:0];
            nx.quo = st.quo | (19'd1 << k);
        end
        return nx;
    endfunction

    // one digit of the integer square root at result bit b
    function automatic sqrt_t sqrt_step(sqrt_t st, int b);
        sqrt_t       nx;
        logic [34:0] trial;
        nx = st;
        trial = ({18'd0, st.res} << (b + 1)) + (35'd1 << (2 * b));
        if ({2'd0, st.rem} >= trial)
        begin
            nx.rem = st.rem - trial[32:0];
            nx.res = st.res | (17'd1 << b);
        end
        return nx;
    endfunction

    // one restoring step of the phase divider at quotient bit k
    function automatic phdiv_t phdiv_step(phdiv_t st, logic [15:0] den, int k);
        phdiv_t      nx;
        logic [30:0] sh;
        nx = st;
        sh = {15'd0, den} << k;
        if (st.rem >= sh)
        begin
            nx.rem = st.rem - sh;
            nx.quo = st.quo | (16'd1 << k);
        end
        return nx;
    endfunction

endpackage

>>> hw/rtl/twr_radius.sv
// ----------------------------------------------------------------------------
// twr_radius
// normalized radius: per-axis squared ratio, mean over three axes,
// saturation at four, then integer square root, all as pipeline stages
// ----------------------------------------------------------------------------
module twr_radius (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] pos_x,
    input  logic [11:0] pos_y,
    input  logic [11:0] pos_z,
    input  logic [11:0] size_x,
    input  logic [11:0] size_y,
    input  logic [11:0] size_z,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [16:0] radius
);

    localparam int ST_SQ    = 1;
    localparam int ST_DIV0  = 2;
    localparam int ST_SUM   = ST_DIV0 + twr_pkg::AX_DIV_STAGES;
    localparam int ST_MUL   = ST_SUM + 1;
    localparam int ST_ROOT  = ST_MUL + 1;
    localparam int ST_SQRT0 = ST_ROOT + 1;
    localparam int NS       = ST_SQRT0 + twr_pkg::SQRT_STAGES;

    logic [NS-1:0] v_reg;
    logic [NS:0]   ld;
    logic [NS-1:0] v_in;

    logic [11:0] praw [3];
    logic [11:0] sraw [3];
    logic [11:0] mag  [3];
    logic [11:0] ext  [3];
    logic [11:0] m_reg [3];
    logic [11:0] e_reg [3];
    logic [23:0] msq  [3];
    logic [23:0] esq  [3];

    twr_pkg::axdiv_t dv_reg  [ST_SQ:ST_SUM-1][3];
    twr_pkg::axdiv_t dv_next [ST_DIV0:ST_SUM-1][3];
    logic [23:0]     den_reg [ST_SQ:ST_SUM-2][3];
    logic            ovf_reg [ST_SQ:ST_SUM-1][3];

    logic [20:0] term [3];
    logic [20:0] sum_reg;
    logic [40:0] prod_reg;
    logic [19:0] q3;
    logic [17:0] r2;

    twr_pkg::sqrt_t sq_reg  [ST_ROOT:NS-1];
    twr_pkg::sqrt_t sq_next [ST_SQRT0:NS-1];

    // stage load enables, a stage loads when empty or when its successor loads
    always_comb
    begin
        ld[NS] = out_ready;
        for (int s = NS - 1; s >= 0; s--)
        begin
            ld[s] = !v_reg[s] || ld[s + 1];
        end
    end

    assign v_in      = {v_reg[NS-2:0], in_valid};
    assign in_ready  = ld[0];
    assign out_valid = v_reg[NS-1];
    assign radius    = sq_reg[NS-1].res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < NS; s++)
            begin
                if (ld[s])
                begin
                    v_reg[s] <= v_in[s];
                end
            end
        end
    end

    // magnitudes and extents, zero extent counts as one
    assign praw[0] = pos_x;
    assign praw[1] = pos_y;
    assign praw[2] = pos_z;
    assign sraw[0] = size_x;
    assign sraw[1] = size_y;
    assign sraw[2] = size_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = praw[i][11] ? (~praw[i] + 12'd1) : praw[i];
            ext[i] = (sraw[i] == 12'd0) ? 12'd1 : sraw[i];
            msq[i] = 24'(m_reg[i]) * 24'(m_reg[i]);
            esq[i] = 24'(e_reg[i]) * 24'(e_reg[i]);
        end
    end

    // divider steps, two quotient bits per stage
    always_comb
    begin
        twr_pkg::axdiv_t tmp;
        int              jj;
        for (int s = ST_DIV0; s < ST_SUM; s++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tmp = dv_reg[s-1][i];
                for (int j = 0; j < 2; j++)
                begin
                    jj = 2 * (s - ST_DIV0) + j;
                    if (jj < twr_pkg::AX_Q_BITS)
                    begin
                        tmp = twr_pkg::axdiv_step(tmp, den_reg[s-1][i],
                                                  twr_pkg::AX_Q_BITS - 1 - jj);
                    end
                end
                dv_next[s][i] = tmp;
            end
        end
    end

    // term per axis, clamped where it alone already saturates the radius
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            term[i] = ovf_reg[ST_SUM-1][i] ? 21'h80000
                                           : {2'b00, dv_reg[ST_SUM-1][i].quo};
        end
    end

    // mean via reciprocal, saturate r2 at four
    assign q3 = prod_reg[40:21];
    assign r2 = (q3 > 20'd131072) ? 18'd131072 : q3[17:0];

    // square root steps, two result bits per stage
    always_comb
    begin
        twr_pkg::sqrt_t tmp;
        int             jj;
        for (int s = ST_SQRT0; s < NS; s++)
        begin
            tmp = sq_reg[s-1];
            for (int j = 0; j < 2; j++)
            begin
                jj = 2 * (s - ST_SQRT0) + j;
                if (jj < twr_pkg::SQRT_BITS)
                begin
                    tmp = twr_pkg::sqrt_step(tmp, twr_pkg::SQRT_BITS - 1 - jj);
                end
            end
            sq_next[s] = tmp;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_reg[i] <= mag[i];
                e_reg[i] <= ext[i];
            end
        end
        if (ld[ST_SQ])
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_reg[ST_SQ][i].rem <= {msq[i][22:0], 15'd0};
                dv_reg[ST_SQ][i].quo <= '0;
                den_reg[ST_SQ][i]    <= esq[i];
                ovf_reg[ST_SQ][i]    <= {2'b00, m_reg[i]} >= {e_reg[i], 2'b00};
            end
        end
        for (int s = ST_DIV0; s < ST_SUM; s++)
        begin
            if (ld[s])
            begin
                dv_reg[s]  <= dv_next[s];
                ovf_reg[s] <= ovf_reg[s-1];
            end
        end
        // divisor travels only as far as the last divider step reads it
        for (int s = ST_DIV0; s < ST_SUM - 1; s++)
        begin
            if (ld[s])
            begin
                den_reg[s] <= den_reg[s-1];
            end
        end
        if (ld[ST_SUM])
        begin
            sum_reg <= term[0] + term[1] + term[2];
        end
        if (ld[ST_MUL])
        begin
            prod_reg <= 41'(sum_reg) * 41'(twr_pkg::RECIP3);
        end
        if (ld[ST_ROOT])
        begin
            sq_reg[ST_ROOT].rem <= {r2, 15'd0};
            sq_reg[ST_ROOT].res <= '0;
        end
        for (int s = ST_SQRT0; s < NS; s++)
        begin
            if (ld[s])
            begin
                sq_reg[s] <= sq_next[s];
            end
        end
    end

endmodule

>>> hw/rtl/twr_phase.sv
// ----------------------------------------------------------------------------
// twr_phase
// taper phase: flags radii inside the flat region and divides the distance
// into the taper by its width, Q16, clamped to one
// ----------------------------------------------------------------------------
module twr_phase (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [16:0] radius,
    input  logic [15:0] taper_a,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [16:0] phase,
    output logic        unity
);

    localparam int NS = 1 + twr_pkg::PH_STAGES;

    logic [NS-1:0] v_reg;
    logic [NS:0]   ld;
    logic [NS-1:0] v_in;

    logic [16:0] flat_end;
    logic [16:0] excess;

    twr_pkg::phdiv_t ph_reg  [0:NS-1];
    twr_pkg::phdiv_t ph_next [1:NS-1];
    logic            unity_reg [0:NS-1];
    logic            sat_reg   [0:NS-1];

    // stage load enables
    always_comb
    begin
        ld[NS] = out_ready;
        for (int s = NS - 1; s >= 0; s--)
        begin
            ld[s] = !v_reg[s] || ld[s + 1];
        end
    end

    assign v_in      = {v_reg[NS-2:0], in_valid};
    assign in_ready  = ld[0];
    assign out_valid = v_reg[NS-1];
    assign unity     = unity_reg[NS-1];
    assign phase     = sat_reg[NS-1] ? 17'h10000 : {1'b0, ph_reg[NS-1].quo};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < NS; s++)
            begin
                if (ld[s])
                begin
                    v_reg[s] <= v_in[s];
                end
            end
        end
    end

    // end of the flat region and distance past it
    assign flat_end = 17'(twr_pkg::ONE_Q15) - {1'b0, taper_a};
    assign excess   = radius - flat_end;

    // divider steps
    always_comb
    begin
        twr_pkg::phdiv_t tmp;
        int              jj;
        for (int s = 1; s < NS; s++)
        begin
            tmp = ph_reg[s-1];
            for (int j = 0; j < 2; j++)
            begin
                jj = 2 * (s - 1) + j;
                if (jj < twr_pkg::PH_Q_BITS)
                begin
                    tmp = twr_pkg::phdiv_step(tmp, taper_a,
                                              twr_pkg::PH_Q_BITS - 1 - jj);
                end
            end
            ph_next[s] = tmp;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            unity_reg[0]  <= radius <= flat_end;
            sat_reg[0]    <= excess >= {1'b0, taper_a};
            ph_reg[0].rem <= {excess[14:0], 16'd0};
            ph_reg[0].quo <= '0;
        end
        for (int s = 1; s < NS; s++)
        begin
            if (ld[s])
            begin
                ph_reg[s]    <= ph_next[s];
                unity_reg[s] <= unity_reg[s-1];
                sat_reg[s]   <= sat_reg[s-1];
            end
        end
    end

endmodule

>>> hw/rtl/twr_taper.sv
// ----------------------------------------------------------------------------
// twr_taper
// raised cosine of the phase through an odd sine polynomial, blended
// between the floor level and one
// ----------------------------------------------------------------------------
module twr_taper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [16:0] phase,
    input  logic        unity,
    input  logic [15:0] floor_q,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] weight
);

    localparam int NS = 12;

    logic [NS-1:0] v_reg;
    logic [NS:0]   ld;
    logic [NS-1:0] v_in;

    logic        unity_reg [0:10];
    logic        pos_reg   [0:8];
    logic [15:0] u_reg     [0:5];
    logic [15:0] u2_reg    [1:4];
    logic [15:0] u3_reg    [2:5];
    logic [15:0] u5_reg    [3:5];
    logic [15:0] u7_reg    [4:5];
    logic [15:0] u9_reg;

    logic [31:0] sq_u;
    logic [31:0] sq_u3;
    logic [31:0] sq_u5;
    logic [31:0] sq_u7;
    logic [31:0] sq_u9;

    logic [45:0] p1_reg, p3_reg, p5_reg, p7_reg, p9_reg;
    logic signed [47:0] sa_reg, sb_reg, acc_reg;

    logic [47:0] acc_pos;
    logic [47:0] rnd;
    logic [18:0] s_raw;
    logic [15:0] s_val;
    logic [16:0] h16;
    logic [32:0] prod_reg;
    logic [32:0] prod_rnd;
    logic [15:0] blend_reg;
    logic [15:0] w_reg;

    // stage load enables
    always_comb
    begin
        ld[NS] = out_ready;
        for (int s = NS - 1; s >= 0; s--)
        begin
            ld[s] = !v_reg[s] || ld[s + 1];
        end
    end

    assign v_in      = {v_reg[NS-2:0], in_valid};
    assign in_ready  = ld[0];
    assign out_valid = v_reg[NS-1];
    assign weight    = w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < NS; s++)
            begin
                if (ld[s])
                begin
                    v_reg[s] <= v_in[s];
                end
            end
        end
    end

    // power chain, each power truncated to Q16
    assign sq_u  = 32'(u_reg[0]) * 32'(u_reg[0]);
    assign sq_u3 = 32'(u2_reg[1]) * 32'(u_reg[1]);
    assign sq_u5 = 32'(u3_reg[2]) * 32'(u2_reg[2]);
    assign sq_u7 = 32'(u5_reg[3]) * 32'(u2_reg[3]);
    assign sq_u9 = 32'(u7_reg[4]) * 32'(u2_reg[4]);

    // clamp, round to Q15, then half of one plus cosine
    assign acc_pos  = acc_reg[47] ? 48'd0 : acc_reg;
    assign rnd      = acc_pos + 48'h10000000;
    assign s_raw    = rnd[47:29];
    assign s_val    = (s_raw > 19'd32768) ? twr_pkg::ONE_Q15 : s_raw[15:0];
    assign h16      = pos_reg[8] ? (17'd32768 - {1'b0, s_val})
                                 : (17'd32768 + {1'b0, s_val});
    assign prod_rnd = prod_reg + 33'd32768;

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            unity_reg[0] <= unity;
            pos_reg[0]   <= phase >= 17'd32768;
            u_reg[0]     <= (phase >= 17'd32768) ? 16'(phase - 17'd32768)
                                                 : 16'(17'd32768 - phase);
        end
        for (int s = 1; s < 11; s++)
        begin
            if (ld[s])
            begin
                unity_reg[s] <= unity_reg[s-1];
            end
        end
        for (int s = 1; s < 9; s++)
        begin
            if (ld[s])
            begin
                pos_reg[s] <= pos_reg[s-1];
            end
        end
        for (int s = 1; s < 6; s++)
        begin
            if (ld[s])
            begin
                u_reg[s] <= u_reg[s-1];
            end
        end
        if (ld[1])
        begin
            u2_reg[1] <= sq_u[31:16];
        end
        for (int s = 2; s < 5; s++)
        begin
            if (ld[s])
            begin
                u2_reg[s] <= u2_reg[s-1];
            end
        end
        if (ld[2])
        begin
            u3_reg[2] <= sq_u3[31:16];
        end
        for (int s = 3; s < 6; s++)
        begin
            if (ld[s])
            begin
                u3_reg[s] <= u3_reg[s-1];
            end
        end
        if (ld[3])
        begin
            u5_reg[3] <= sq_u5[31:16];
        end
        for (int s = 4; s < 6; s++)
        begin
            if (ld[s])
            begin
                u5_reg[s] <= u5_reg[s-1];
            end
        end
        if (ld[4])
        begin
            u7_reg[4] <= sq_u7[31:16];
        end
        if (ld[5])
        begin
            u7_reg[5] <= u7_reg[4];
            u9_reg    <= sq_u9[31:16];
        end
        if (ld[6])
        begin
            p1_reg <= 46'(twr_pkg::SIN_C1) * 46'(u_reg[5]);
            p3_reg <= 46'(twr_pkg::SIN_C3) * 46'(u3_reg[5]);
            p5_reg <= 46'(twr_pkg::SIN_C5) * 46'(u5_reg[5]);
            p7_reg <= 46'(twr_pkg::SIN_C7) * 46'(u7_reg[5]);
            p9_reg <= 46'(twr_pkg::SIN_C9) * 46'(u9_reg);
        end
        if (ld[7])
        begin
            sa_reg <= $signed({2'b00, p1_reg}) - $signed({2'b00, p3_reg})
                    + $signed({2'b00, p5_reg});
            sb_reg <= $signed({2'b00, p9_reg}) - $signed({2'b00, p7_reg});
        end
        if (ld[8])
        begin
            acc_reg <= sa_reg + sb_reg;
        end
        if (ld[9])
        begin
            prod_reg <= 33'(twr_pkg::ONE_Q15 - floor_q) * 33'(h16);
        end
        if (ld[10])
        begin
            blend_reg <= floor_q + prod_rnd[31:16];
        end
        // flat region overrides the blend
        if (ld[11])
        begin
            w_reg <= unity_reg[10] ? twr_pkg::ONE_Q15 : blend_reg;
        end
    end

endmodule

>>> hw/rtl/tukey_radial_window_weight.sv
// ----------------------------------------------------------------------------
// tukey_radial_window_weight
// radial tukey taper weight for a stream of 3-d k-space coordinates
// ----------------------------------------------------------------------------
// usage:
//   input channel pos_valid / pos_stall carries one signed coordinate
//   (pos_x, pos_y, pos_z) per request; output channel weight_valid /
//   weight_stall carries one Q1.15 weight per request, in order.
//   configuration is written through cfg_we / cfg_index / cfg_data while
//   no request is in flight; indexes beyond the register list are ignored.
// pipeline and throughput:
//   one request per cycle is sustained while weight_stall stays low. the
//   pipeline depth is set by the pipelined restoring dividers (two
//   quotient bits per stage), the square root (two result bits per
//   stage) and the registered sine polynomial chain.
// reset:
//   all stages empty, registers at their reset values (taper half, floor
//   zero, extents 2048).
// stall:
//   a stalled weight holds; empty stages keep filling, and pos_stall rises
//   only once every stage holds a request.
// ----------------------------------------------------------------------------
module tukey_radial_window_weight (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [twr_pkg::IDX_W-1:0]   cfg_index,
    input  logic [twr_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        pos_valid,
    output logic                        pos_stall,
    input  logic signed [twr_pkg::COORD_W-1:0] pos_x,
    input  logic signed [twr_pkg::COORD_W-1:0] pos_y,
    input  logic signed [twr_pkg::COORD_W-1:0] pos_z,
    output logic                        weight_valid,
    input  logic                        weight_stall,
    output logic [twr_pkg::WEIGHT_W-1:0] weight
);

    logic [15:0] taper_fraction_reg;
    logic [15:0] floor_level_reg;
    logic [11:0] size_x_reg;
    logic [11:0] size_y_reg;
    logic [11:0] size_z_reg;

    logic [15:0] taper_a;
    logic [15:0] floor_q;

    logic        rad_valid, rad_ready;
    logic [16:0] radius;
    logic        ph_valid, ph_ready;
    logic [16:0] phase;
    logic        unity;
    logic        tp_valid, tp_ready;
    logic [15:0] tp_weight;
    logic        in_ready;

    logic        weight_valid_reg;
    logic [15:0] weight_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taper_fraction_reg <= 16'd16384;
            floor_level_reg    <= 16'd0;
            size_x_reg         <= 12'd2048;
            size_y_reg         <= 12'd2048;
            size_z_reg         <= 12'd2048;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                twr_pkg::REG_TAPER:  taper_fraction_reg <= cfg_data;
                twr_pkg::REG_FLOOR:  floor_level_reg    <= cfg_data;
                twr_pkg::REG_SIZE_X: size_x_reg         <= cfg_data[11:0];
                twr_pkg::REG_SIZE_Y: size_y_reg         <= cfg_data[11:0];
                twr_pkg::REG_SIZE_Z: size_z_reg         <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // taper width in 1..one, floor at most one
    assign taper_a = (taper_fraction_reg == 16'd0) ? 16'd1 :
                     (taper_fraction_reg > twr_pkg::ONE_Q15) ? twr_pkg::ONE_Q15 :
                     taper_fraction_reg;
    assign floor_q = (floor_level_reg > twr_pkg::ONE_Q15) ? twr_pkg::ONE_Q15
                                                          : floor_level_reg;

    twr_radius u_radius (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pos_valid),
        .in_ready  (in_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .size_x    (size_x_reg),
        .size_y    (size_y_reg),
        .size_z    (size_z_reg),
        .out_valid (rad_valid),
        .out_ready (rad_ready),
        .radius    (radius)
    );

    twr_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rad_valid),
        .in_ready  (rad_ready),
        .radius    (radius),
        .taper_a   (taper_a),
        .out_valid (ph_valid),
        .out_ready (ph_ready),
        .phase     (phase),
        .unity     (unity)
    );

    twr_taper u_taper (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ph_valid),
        .in_ready  (ph_ready),
        .phase     (phase),
        .unity     (unity),
        .floor_q   (floor_q),
        .out_valid (tp_valid),
        .out_ready (tp_ready),
        .weight    (tp_weight)
    );

    assign pos_stall = !in_ready;

    // output register
    assign tp_ready = !weight_valid_reg || !weight_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_valid_reg <= 1'b0;
        end
        else if (tp_ready)
        begin
            weight_valid_reg <= tp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tp_ready && tp_valid)
        begin
            weight_reg <= tp_weight;
        end
    end

    assign weight_valid = weight_valid_reg;
    assign weight       = weight_reg;

endmodule

>>> hw/rtl/twr_port_checker.sv
// ----------------------------------------------------------------------------
// twr_port_checker
// port-level checks of the radial tukey window weight block
// ----------------------------------------------------------------------------
`include "tukey_radial_window_weight_defines.svh"

module twr_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pos_stall,
    input logic        weight_valid,
    input logic        weight_stall,
    input logic [15:0] weight
);

    // a weight never exceeds one
    `TWR_ASSERT_IMPLY(a_weight_range, clk, rst_n, weight_valid, weight <= 16'd32768, "weight above one")

    // input backs up only when the output is held by the receiver
    `TWR_ASSERT_IMPLY(a_stall_cause, clk, rst_n, pos_stall, weight_valid && weight_stall, "input stalled without output backpressure")

    // a held weight stays put
    `TWR_ASSERT_NEXT(a_weight_hold, clk, rst_n, weight_valid && weight_stall, weight_valid && $stable(weight), "stalled weight changed")

endmodule

bind tukey_radial_window_weight twr_port_checker u_port_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pos_stall    (pos_stall),
    .weight_valid (weight_valid),
    .weight_stall (weight_stall),
    .weight       (weight)
);
